// ===== hdl/nps_pkg.sv =====
package nps_pkg;

  localparam int IDX_W               = 8;
  localparam int CH_W                = 8;
  localparam int SQ_W                = 2 * CH_W;
  localparam int DIST_W              = 18;
  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  // Travels alongside one palette read through the search pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    color_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

endpackage

// ===== hdl/nearest_palette_color_search_unit.sv =====
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: entry_index, red, green, blue
//                                              tuser: opcode, skip_zero
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: best_index, best_distance
//
// A write is accepted, then loads the result register.
// A query makes one palette read per cycle from the single read port, starting at
// entry 1 with skip_zero, then passes through the distance/compare tail.
// The next item is accepted while a finished result still waits in the output
// register; a stalled m_axis only holds the block in its final step.
// rst is synchronous, active high; palette contents are not cleared.
module nearest_palette_color_search_unit
  import nps_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] opcode, [1] skip_zero
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] best_index, [25:8] best_distance, [31:26] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  op_t               in_op;
  logic [IDX_W-1:0]  in_index;
  color_t            in_color;
  ram_req_t          ram_req;
  color_t            entry;
  color_t            query;
  tag_t              tag_rd;
  tag_t              tag_cmp;
  logic [DIST_W-1:0] sq_dist;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;

  // Unpack the input item.
  assign in_op          = op_t'(s_axis_tuser[0]);
  assign in_index       = s_axis_tdata[7:0];
  assign in_color.red   = s_axis_tdata[15:8];
  assign in_color.green = s_axis_tdata[23:16];
  assign in_color.blue  = s_axis_tdata[31:24];

  // Sequencer: accepts items, issues palette reads, tracks the best entry and
  // owns the output register. Reads and writes never overlap, since writes are
  // taken only while no scan is running.
  nps_search_ctrl #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (in_op),
    .in_index  (in_index),
    .in_color  (in_color),
    .in_skip   (s_axis_tuser[1]),
    .ram_req   (ram_req),
    .query     (query),
    .tag_rd    (tag_rd),
    .sq_dist   (sq_dist),
    .tag_cmp   (tag_cmp),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (best_index),
    .out_dist  (best_distance)
  );

  // Palette store, one write and one registered read per cycle.
  nps_palette_ram #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (entry)
  );

  // Squared distance of the entry just read; squares registered, sum feeds compare.
  nps_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .entry   (entry),
    .query   (query),
    .tag_in  (tag_rd),
    .sq_dist (sq_dist),
    .tag_out (tag_cmp)
  );

  // Pack the result item.
  assign m_axis_tdata = {(OUT_TDATA_W - IDX_W - DIST_W)'(0), best_distance, best_index};

endmodule

// ===== hdl/nps_palette_ram.sv =====
module nps_palette_ram
  import nps_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic     clk,
  input  ram_req_t req,
  output color_t   rd_data
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  color_t mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

// ===== hdl/nps_dist_unit.sv =====
module nps_dist_unit
  import nps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  color_t            entry,
  input  color_t            query,
  input  tag_t              tag_in,
  output logic [DIST_W-1:0] sq_dist,
  output tag_t              tag_out
);

  logic [CH_W-1:0] d_red, d_green, d_blue;
  logic [SQ_W-1:0] sq_red, sq_green, sq_blue;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign d_red   = abs_diff(entry.red,   query.red);
  assign d_green = abs_diff(entry.green, query.green);
  assign d_blue  = abs_diff(entry.blue,  query.blue);

  // Register the three squares, then sum them on the way to the compare.
  always_ff @(posedge clk) begin
    sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  assign sq_dist = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);

endmodule

// ===== hdl/nps_search_ctrl.sv =====
module nps_search_ctrl
  import nps_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  input  logic [IDX_W-1:0]  in_index,
  input  color_t            in_color,
  input  logic              in_skip,
  output ram_req_t          ram_req,
  output color_t            query,
  output tag_t              tag_rd,
  input  logic [DIST_W-1:0] sq_dist,
  input  tag_t              tag_cmp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_index,
  output logic [DIST_W-1:0] out_dist
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(PALETTE_ENTRIES);

  state_t            state, state_next;
  logic [AW-1:0]     addr;
  logic              first_pend;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_dist;
  logic              accept;
  logic              issue;
  logic              load_out;
  logic              take_best;

  assign accept    = in_valid && in_ready;
  assign take_best = tag_cmp.valid && (tag_cmp.first || (sq_dist < best_dist));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_op == OP_QUERY) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (addr == LAST_ADDR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_cmp.valid && tag_cmp.last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    issue            = 1'b0;
    load_out         = 1'b0;
    ram_req.wr_en    = 1'b0;
    ram_req.wr_addr  = in_index;
    ram_req.wr_data  = in_color;
    ram_req.rd_addr  = IDX_W'(addr);
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ram_req.wr_en = in_valid && (in_op == OP_WRITE) && ({1'b0, in_index} < DEPTH_EXT);
      end
      ST_SCAN:  issue    = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   load_out = !out_valid || out_ready;
      default: ;
    endcase
    ram_req.rd_en = issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the query and walk the read address.
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_QUERY)) begin
      query      <= in_color;
      addr       <= in_skip ? AW'(1) : '0;
      first_pend <= 1'b1;
    end else if (issue) begin
      addr       <= addr + AW'(1);
      first_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
    end else begin
      tag_rd.valid <= issue;
      tag_rd.first <= first_pend;
      tag_rd.last  <= (addr == LAST_ADDR);
      tag_rd.idx   <= IDX_W'(addr);
    end
  end

  // Running minimum: strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_WRITE)) begin
      best_index <= '0;
      best_dist  <= '0;
    end else if (accept) begin
      best_index <= IDX_W'(in_skip);
      best_dist  <= '0;
    end else if (take_best) begin
      best_index <= tag_cmp.idx;
      best_dist  <= sq_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index <= best_index;
      out_dist  <= best_dist;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import nps_pkg::*;

  localparam int PAL_N     = DEF_PALETTE_ENTRIES;
  localparam int N_RANDOM  = 1220;
  // Longest gap of a query plus margin; used for the quiet window at the end.
  localparam int QUIET_CYC = PAL_N + 32;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } result_t;

  // One row of stimulus; want holds a hand-written expectation when typed is set.
  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] idx;
    color_t           col;
    logic             skip;
    bit               typed;
    result_t          want;
  } stim_t;

  typedef struct {
    bit      typed;
    result_t want;
  } note_t;

  typedef enum int {
    RX_OPEN,
    RX_SPOTTY,
    RX_BURSTY
  } rx_mode_t;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [0] opcode, [1] skip_zero
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] best_index, [25:8] best_distance, [31:26] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow palette, updated as each write item is accepted.
  color_t  palette_model [PAL_N];
  stim_t   directed_rows [$];
  note_t   sent_notes [$];
  result_t expected_results [$];
  int      mismatch_count = 0;
  int      burst_left     = 0;

  nearest_palette_color_search_unit #(
    .PALETTE_ENTRIES(PAL_N)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned chan_sq(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    int unsigned d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // Scan the shadow palette; strict less-than keeps the lowest index on a tie.
  function automatic result_t nearest_color(input color_t q, input logic skip);
    result_t     r;
    int unsigned d;
    int unsigned best;
    int          i;
    best  = 32'hFFFF_FFFF;
    r.idx = skip ? 8'd1 : 8'd0;
    r.distance = '0;
    for (i = skip ? 1 : 0; i < PAL_N; i++) begin
      d = chan_sq(palette_model[i].red, q.red) + chan_sq(palette_model[i].green, q.green)
        + chan_sq(palette_model[i].blue, q.blue);
      if (d < best) begin
        best       = d;
        r.idx      = i[IDX_W-1:0];
        r.distance = d[DIST_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic add_row(input op_t op, input int idx, input int r, input int g, input int b,
                         input bit skip, input bit typed, input int e_idx, input int e_dist);
    stim_t s;
    s.op            = op;
    s.idx           = idx[IDX_W-1:0];
    s.col.red       = r[CH_W-1:0];
    s.col.green     = g[CH_W-1:0];
    s.col.blue      = b[CH_W-1:0];
    s.skip          = skip;
    s.typed         = typed;
    s.want.idx      = e_idx[IDX_W-1:0];
    s.want.distance = e_dist[DIST_W-1:0];
    directed_rows.push_back(s);
  endtask

  // Send one item; between bursts drop tvalid for a random gap first.
  task automatic feed(input stim_t s);
    note_t nt;
    int    gap;
    if (burst_left == 0) begin
      // Mostly short gaps, now and then a long one so items land on every phase of a scan.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    nt.typed = s.typed;
    nt.want  = s.want;
    sent_notes.push_back(nt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.col.blue, s.col.green, s.col.red, s.idx};
    s_axis_tuser  <= {s.skip, s.op};
    // Hold the item until an edge sees tvalid and tready together.
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Receiver: from time to time pick a new stall style at random (open, spotty or bursty).
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       run_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      RX_SPOTTY: begin
        m_axis_tready <= ($urandom_range(0, 9) > 2);
      end
      default: begin
        if (run_left == 0) begin
          m_axis_tready <= ~m_axis_tready;
          run_left      <= m_axis_tready ? $urandom_range(1, 15) : $urandom_range(1, 8);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    note_t   nt;
    color_t  q;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx      = m_axis_tdata[7:0];
        got.distance = m_axis_tdata[25:8];
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending: actual best_index %0d best_distance %0d",
                   $time, got.idx, got.distance);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t: best_index mismatch: expected %0d, actual %0d",
                     $time, want.idx, got.idx);
            mismatch_count++;
          end
          if (got.distance !== want.distance) begin
            $display("%0t: best_distance mismatch: expected %0d, actual %0d",
                     $time, want.distance, got.distance);
            mismatch_count++;
          end
          if (m_axis_tdata[31:26] !== '0) begin
            $display("%0t: tdata fill mismatch: expected 0, actual %0h",
                     $time, m_axis_tdata[31:26]);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        nt      = sent_notes.pop_front();
        q.red   = s_axis_tdata[15:8];
        q.green = s_axis_tdata[23:16];
        q.blue  = s_axis_tdata[31:24];
        if (op_t'(s_axis_tuser[0]) == OP_WRITE) begin
          palette_model[s_axis_tdata[7:0]] = q;
          want = '0;
        end else begin
          want = nearest_color(q, s_axis_tuser[1]);
        end
        expected_results.push_back(nt.typed ? nt.want : want);
      end
    end
  end

  initial begin
    stim_t s;
    int    i;
    int    pick;
    int    k;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill entries 1..255 with black; entry 0 stays unwritten, so early queries skip it.
    for (i = 1; i < PAL_N; i++) begin
      s.op    = OP_WRITE;
      s.idx   = i[IDX_W-1:0];
      s.col   = '0;
      s.skip  = 1'b0;
      s.typed = 1'b0;
      s.want  = '0;
      feed(s);
    end

    // Directed rows: corner colors, ties, skipped entry zero, exact hits.
    add_row(OP_QUERY, 0, 255, 255, 255, 1, 1, 1, 195075);  // farthest corner, tie on all
    add_row(OP_QUERY, 0, 0, 0, 0, 1, 1, 1, 0);
    add_row(OP_WRITE, 0, 255, 255, 255, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 255, 255, 255, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 255, 255, 255, 1, 1, 1, 195075);  // transparent entry ignored
    add_row(OP_QUERY, 255, 0, 0, 0, 0, 1, 1, 0);           // index field ignored on query
    add_row(OP_WRITE, 255, 255, 0, 0, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 255, 0, 0, 1, 1, 255, 0);
    add_row(OP_QUERY, 0, 200, 0, 0, 1, 0, 0, 0);
    add_row(OP_WRITE, 128, 0, 255, 0, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 0, 200, 0, 0, 0, 0, 0);
    add_row(OP_WRITE, 64, 0, 0, 255, 0, 1, 0, 0);
    add_row(OP_WRITE, 200, 0, 0, 255, 1, 1, 0, 0);         // duplicate color for a tie
    add_row(OP_QUERY, 0, 0, 0, 254, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 128, 128, 128, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 128, 128, 128, 1, 0, 0, 0);
    add_row(OP_WRITE, 165, 8'hAA, 8'h55, 8'h0F, 0, 1, 0, 0);
    add_row(OP_WRITE, 90, 8'h55, 8'hAA, 8'hF0, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 8'hAA, 8'h55, 8'h0F, 1, 0, 0, 0);
    add_row(OP_QUERY, 0, 8'h55, 8'hAA, 8'hF0, 0, 0, 0, 0);
    add_row(OP_WRITE, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_QUERY, 0, 255, 255, 255, 0, 0, 0, 0);
    foreach (directed_rows[j]) feed(directed_rows[j]);

    // Random part: every entry is written by now, so any query is legal.
    for (i = 0; i < N_RANDOM; i++) begin
      s.op    = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_QUERY;
      s.idx   = IDX_W'($urandom_range(0, 255));
      s.skip  = 1'($urandom_range(0, 1));
      s.typed = 1'b0;
      s.want  = '0;
      pick    = $urandom_range(0, 99);
      k       = $urandom_range(0, PAL_N - 1);
      if (pick < 20) begin
        // Copy a palette color: duplicates on writes, exact hits on queries.
        s.col = palette_model[k];
      end else if (pick < 30) begin
        s.col.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        s.col.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        s.col.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        s.col = (3 * CH_W)'($urandom());
      end
      feed(s);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0 || sent_notes.size() != 0) @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nps_pkg.sv
hdl/nps_palette_ram.sv
hdl/nps_dist_unit.sv
hdl/nps_search_ctrl.sv
hdl/nearest_palette_color_search_unit.sv
dv/tb_top.sv
